FILE: rtl/core/qnd_pkg.sv
// Shared types, codes and constants for the QMQP netstring deframer.
package qnd_pkg;

  localparam int LEN_BITS_DEF = 32;
  localparam int BUDGET_W     = 16;
  localparam int LIMIT_W      = 16;
  localparam int CAP_W        = 29;
  localparam int APB_DW       = 32;
  localparam int APB_AW       = 4;
  localparam int EVQ_DEPTH    = 4;
  localparam int EVQ_PTR_W    = $clog2(EVQ_DEPTH);

  localparam logic [BUDGET_W-1:0] RST_OUTER_BUDGET = 16'd100;
  localparam logic [LIMIT_W-1:0]  RST_ADDR_LIMIT   = 16'd1000;
  localparam logic [CAP_W-1:0]    RST_LENGTH_CAP   = 29'd200000000;

  localparam logic [7:0] ASCII_COLON = 8'h3a;
  localparam logic [7:0] ASCII_COMMA = 8'h2c;
  localparam logic [7:0] ASCII_ZERO  = 8'h30;

  // Register indexes (paddr[3:2])
  localparam logic [1:0] REG_OUTER_BUDGET = 2'd0;
  localparam logic [1:0] REG_ADDR_LIMIT   = 2'd1;
  localparam logic [1:0] REG_LENGTH_CAP   = 2'd2;

  typedef enum logic [3:0] {
    PH_OUTER  = 4'd0,
    PH_MLEN   = 4'd1,
    PH_MSG    = 4'd2,
    PH_MCOMMA = 4'd3,
    PH_SLEN   = 4'd4,
    PH_SBODY  = 4'd5,
    PH_SCOMMA = 4'd6,
    PH_RLEN   = 4'd7,
    PH_RBODY  = 4'd8,
    PH_RCOMMA = 4'd9,
    PH_FINAL  = 4'd10,
    PH_HALT   = 4'd11
  } phase_t;

  typedef enum logic [2:0] {
    EV_MSG  = 3'd0,
    EV_SND  = 3'd1,
    EV_RCP  = 3'd2,
    EV_SEND = 3'd3,
    EV_REND = 3'd4,
    EV_DONE = 3'd5,
    EV_FMT  = 3'd6,
    EV_RES  = 3'd7
  } ev_kind_t;

  typedef struct packed {
    ev_kind_t   kind;
    logic [7:0] data;
    logic       good;
  } ev_t;

  typedef struct packed {
    logic [BUDGET_W-1:0] outer_budget;
    logic [LIMIT_W-1:0]  addr_limit;
    logic [CAP_W-1:0]    len_cap;
  } cfg_t;

endpackage

FILE: rtl/core/qmqp_netstring_deframer.sv
// QMQP netstring deframer: config registers, parser, event queue, output stage.
// Path: events of accepted bytes go into the event queue, then the output register.
// Throughput: one byte per cycle; the parse step (length multiply-by-ten
// accumulate and cap compare) is combinational. The four-entry event queue
// absorbs output stalls, and input stalls only when that queue is full.
// Reset (synchronous): parse restarts, queue and output empty, registers at defaults.
module qmqp_netstring_deframer #(
  parameter int LEN_BITS = qnd_pkg::LEN_BITS_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_data_byte,
  input  logic                       in_first,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [2:0]                 out_event_kind,
  output logic [7:0]                 out_payload,
  output logic                       out_good,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [qnd_pkg::APB_AW-1:0] paddr,
  input  logic [qnd_pkg::APB_DW-1:0] pwdata,
  output logic [qnd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);

  qnd_pkg::cfg_t cfg_r;
  logic          cfg_wr;
  logic [1:0]    reg_idx;
  logic          q_full, q_push, q_pop, q_avail;
  qnd_pkg::ev_t  q_in_ev, q_out_ev;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.outer_budget <= qnd_pkg::RST_OUTER_BUDGET;
      cfg_r.addr_limit   <= qnd_pkg::RST_ADDR_LIMIT;
      cfg_r.len_cap      <= qnd_pkg::RST_LENGTH_CAP;
    end else if (cfg_wr) begin
      case (reg_idx)
        qnd_pkg::REG_OUTER_BUDGET: cfg_r.outer_budget <= pwdata[qnd_pkg::BUDGET_W-1:0];
        qnd_pkg::REG_ADDR_LIMIT:   cfg_r.addr_limit   <= pwdata[qnd_pkg::LIMIT_W-1:0];
        qnd_pkg::REG_LENGTH_CAP:   cfg_r.len_cap      <= pwdata[qnd_pkg::CAP_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      qnd_pkg::REG_OUTER_BUDGET: prdata = qnd_pkg::APB_DW'(cfg_r.outer_budget);
      qnd_pkg::REG_ADDR_LIMIT:   prdata = qnd_pkg::APB_DW'(cfg_r.addr_limit);
      qnd_pkg::REG_LENGTH_CAP:   prdata = qnd_pkg::APB_DW'(cfg_r.len_cap);
      default:                   prdata = '0;
    endcase
  end

  qnd_parser #(
    .LEN_BITS (LEN_BITS)
  ) u_parser (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data_byte (in_data_byte),
    .in_first     (in_first),
    .q_full       (q_full),
    .push         (q_push),
    .push_ev      (q_in_ev)
  );

  qnd_evq u_evq (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (q_push),
    .push_ev (q_in_ev),
    .full    (q_full),
    .pop     (q_pop),
    .pop_ev  (q_out_ev),
    .avail   (q_avail)
  );

  qnd_out u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .avail          (q_avail),
    .ev             (q_out_ev),
    .take           (q_pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_event_kind (out_event_kind),
    .out_payload    (out_payload),
    .out_good       (out_good)
  );

endmodule

FILE: rtl/core/qnd_parser.sv
// Front part: per-byte framing parser that classifies bytes into events.
module qnd_parser #(
  parameter int LEN_BITS = qnd_pkg::LEN_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  qnd_pkg::cfg_t cfg,
  input  logic          in_valid,
  output logic          in_ready,
  input  logic [7:0]    in_data_byte,
  input  logic          in_first,
  input  logic          q_full,
  output logic          push,
  output qnd_pkg::ev_t  push_ev
);

  localparam int CW = (LEN_BITS > qnd_pkg::CAP_W) ? LEN_BITS : qnd_pkg::CAP_W;

  qnd_pkg::phase_t     phase_r, phase_nxt, ph;
  logic [LEN_BITS-1:0] acc_r, acc_nxt, acc;
  logic [LEN_BITS-1:0] bud_r, bud_nxt, bud, bud_dec;
  logic [LEN_BITS-1:0] body_r, body_nxt, body, body_dec;
  logic                abad_r, abad_nxt, abad;
  logic                aok_r, aok_nxt, aok;
  logic                fire;
  logic                ev_valid;
  logic [LEN_BITS-1:0] digit;
  logic [LEN_BITS-1:0] acc_step;
  logic                acc_over_cap;

  assign in_ready = !q_full;
  assign fire     = in_valid && in_ready;
  assign push     = fire && ev_valid;

  // Digit is the signed byte minus '0', wrapped to the length width.
  assign digit    = {{(LEN_BITS-8){in_data_byte[7]}}, in_data_byte}
                    - LEN_BITS'(qnd_pkg::ASCII_ZERO);
  assign acc_step = (acc << 3) + (acc << 1) + digit;
  assign acc_over_cap = CW'(acc) > CW'(cfg.len_cap);
  assign bud_dec  = bud - LEN_BITS'(1);
  assign body_dec = body - LEN_BITS'(1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= qnd_pkg::PH_OUTER;
      acc_r   <= '0;
      bud_r   <= LEN_BITS'(qnd_pkg::RST_OUTER_BUDGET);
      body_r  <= '0;
      abad_r  <= 1'b0;
      aok_r   <= 1'b1;
    end else if (fire) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      bud_r   <= bud_nxt;
      body_r  <= body_nxt;
      abad_r  <= abad_nxt;
      aok_r   <= aok_nxt;
    end
  end

  always_comb begin
    // A first byte restarts the parse before it is handled.
    ph   = in_first ? qnd_pkg::PH_OUTER : phase_r;
    acc  = in_first ? '0 : acc_r;
    bud  = in_first ? LEN_BITS'(cfg.outer_budget) : bud_r;
    body = in_first ? '0 : body_r;
    abad = in_first ? 1'b0 : abad_r;
    aok  = in_first ? 1'b1 : aok_r;

    phase_nxt = ph;
    acc_nxt   = acc;
    bud_nxt   = bud;
    body_nxt  = body;
    abad_nxt  = abad;
    aok_nxt   = aok;
    ev_valid  = 1'b0;
    push_ev.kind = qnd_pkg::EV_FMT;
    push_ev.data = in_data_byte;
    push_ev.good = 1'b0;

    if (ph == qnd_pkg::PH_HALT) begin
      phase_nxt = qnd_pkg::PH_HALT;
    end else if (ph == qnd_pkg::PH_FINAL) begin
      // Closing comma needs no budget.
      phase_nxt = qnd_pkg::PH_HALT;
      ev_valid  = 1'b1;
      if (in_data_byte == qnd_pkg::ASCII_COMMA) begin
        push_ev.kind = qnd_pkg::EV_DONE;
        push_ev.good = aok;
      end
    end else if (bud == '0) begin
      phase_nxt = qnd_pkg::PH_HALT;
      ev_valid  = 1'b1;
    end else begin
      bud_nxt = bud_dec;
      case (ph)
        qnd_pkg::PH_OUTER, qnd_pkg::PH_MLEN, qnd_pkg::PH_SLEN,
        qnd_pkg::PH_RLEN: begin
          if (in_data_byte == qnd_pkg::ASCII_COLON) begin
            acc_nxt = '0;
            if (ph == qnd_pkg::PH_OUTER) begin
              // Outer length now meters the rest of the packet.
              bud_nxt   = acc;
              phase_nxt = qnd_pkg::PH_MLEN;
            end else begin
              body_nxt = acc;
              if (ph == qnd_pkg::PH_MLEN) begin
                phase_nxt = (acc != '0) ? qnd_pkg::PH_MSG : qnd_pkg::PH_MCOMMA;
              end else begin
                abad_nxt = acc >= LEN_BITS'(cfg.addr_limit);
                if (ph == qnd_pkg::PH_SLEN) begin
                  phase_nxt = (acc != '0) ? qnd_pkg::PH_SBODY : qnd_pkg::PH_SCOMMA;
                end else begin
                  phase_nxt = (acc != '0) ? qnd_pkg::PH_RBODY : qnd_pkg::PH_RCOMMA;
                end
              end
            end
          end else if (acc_over_cap) begin
            phase_nxt    = qnd_pkg::PH_HALT;
            ev_valid     = 1'b1;
            push_ev.kind = qnd_pkg::EV_RES;
          end else begin
            acc_nxt = acc_step;
          end
        end
        qnd_pkg::PH_MSG, qnd_pkg::PH_SBODY, qnd_pkg::PH_RBODY: begin
          body_nxt = body_dec;
          ev_valid = 1'b1;
          if (ph == qnd_pkg::PH_MSG) begin
            push_ev.kind = qnd_pkg::EV_MSG;
            if (body_dec == '0) begin
              phase_nxt = qnd_pkg::PH_MCOMMA;
            end
          end else begin
            if (in_data_byte == 8'd0) begin
              abad_nxt = 1'b1;
            end
            if (ph == qnd_pkg::PH_SBODY) begin
              push_ev.kind = qnd_pkg::EV_SND;
              if (body_dec == '0) begin
                phase_nxt = qnd_pkg::PH_SCOMMA;
              end
            end else begin
              push_ev.kind = qnd_pkg::EV_RCP;
              if (body_dec == '0) begin
                phase_nxt = qnd_pkg::PH_RCOMMA;
              end
            end
          end
        end
        qnd_pkg::PH_MCOMMA: begin
          if (in_data_byte != qnd_pkg::ASCII_COMMA) begin
            phase_nxt = qnd_pkg::PH_HALT;
            ev_valid  = 1'b1;
          end else begin
            phase_nxt = qnd_pkg::PH_SLEN;
          end
        end
        qnd_pkg::PH_SCOMMA, qnd_pkg::PH_RCOMMA: begin
          ev_valid = 1'b1;
          if (in_data_byte != qnd_pkg::ASCII_COMMA) begin
            phase_nxt = qnd_pkg::PH_HALT;
          end else begin
            if (abad) begin
              aok_nxt = 1'b0;
            end
            push_ev.kind = (ph == qnd_pkg::PH_SCOMMA) ? qnd_pkg::EV_SEND
                                                      : qnd_pkg::EV_REND;
            push_ev.good = !abad;
            abad_nxt     = 1'b0;
            phase_nxt    = (bud_dec != '0) ? qnd_pkg::PH_RLEN : qnd_pkg::PH_FINAL;
          end
        end
        default: begin
          phase_nxt = qnd_pkg::PH_HALT;
        end
      endcase
    end
  end

  a_err_halts: assert property (@(posedge clk) disable iff (!rst_n)
    (push && (push_ev.kind == qnd_pkg::EV_FMT || push_ev.kind == qnd_pkg::EV_RES ||
              push_ev.kind == qnd_pkg::EV_DONE))
    |=> (phase_r == qnd_pkg::PH_HALT))
    else $error("parser not halted after terminal event");

  a_halt_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == qnd_pkg::PH_HALT && fire && !in_first) |-> !push)
    else $error("event from halted parser");

endmodule

FILE: rtl/core/qnd_evq.sv
// Short event queue between the parser and the output stage.
module qnd_evq (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  qnd_pkg::ev_t push_ev,
  output logic         full,
  input  logic         pop,
  output qnd_pkg::ev_t pop_ev,
  output logic         avail
);

  qnd_pkg::ev_t                    ent_r [qnd_pkg::EVQ_DEPTH];
  logic [qnd_pkg::EVQ_PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [qnd_pkg::EVQ_PTR_W:0]     cnt_r, cnt_nxt;

  assign full   = cnt_r == (qnd_pkg::EVQ_PTR_W+1)'(qnd_pkg::EVQ_DEPTH);
  assign avail  = cnt_r != '0;
  assign pop_ev = ent_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_ev;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("event queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    !avail |-> !pop)
    else $error("event queue underflow");

endmodule

FILE: rtl/core/qnd_out.sv
// Back part: output register that formats queued events into result beats.
module qnd_out (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         avail,
  input  qnd_pkg::ev_t ev,
  output logic         take,
  output logic         out_valid,
  input  logic         out_ready,
  output logic [2:0]   out_event_kind,
  output logic [7:0]   out_payload,
  output logic         out_good
);

  logic         out_valid_r;
  qnd_pkg::ev_t ev_r;
  logic         byte_kind;

  assign take      = avail && (!out_valid_r || out_ready);
  assign byte_kind = ev.kind == qnd_pkg::EV_MSG || ev.kind == qnd_pkg::EV_SND ||
                     ev.kind == qnd_pkg::EV_RCP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      ev_r.kind <= ev.kind;
      // Drop the byte for anything but data beats.
      ev_r.data <= byte_kind ? ev.data : 8'd0;
      ev_r.good <= ev.good;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_event_kind = ev_r.kind;
  assign out_payload    = ev_r.data;
  assign out_good       = ev_r.good;

  a_payload_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ev_r.kind != qnd_pkg::EV_MSG && ev_r.kind != qnd_pkg::EV_SND &&
     ev_r.kind != qnd_pkg::EV_RCP) |-> (ev_r.data == 8'd0))
    else $error("nonzero payload on non-byte beat");

endmodule
